// ===== src/phist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phist_pkg: shared types and constants of the pixel histogram unit
// Mode codes, default sizes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package phist_pkg;

  localparam int unsigned BINS_DEF        = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned OUT_COUNT_W = 32;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_COUNT = 2'd1,
    MODE_READ  = 2'd2
  } phist_mode_e;

  // Controller to datapath
  typedef struct packed {
    logic load_item;  // latch the accepted request
    logic sweep;      // write zero at the sweep pointer and advance it
    logic update;     // write back the incremented bin
    logic out_load;   // load the result register
  } phist_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;  // sweep pointer sits on the last bin
    logic out_free;    // result register can take a new result
    logic item_read;   // latched request is a read
  } phist_status_t;

endpackage
`default_nettype wire

// ===== src/phist_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phist_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module phist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/phist_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phist_ctrl: sequencer of the pixel histogram unit
// Runs the clearing sweep, the read-modify-write of a count and the
// lookup of a read, one request at a time.
// ----------------------------------------------------------------------------
module phist_ctrl
  import phist_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  input  wire logic [MODE_W-1:0] mode_i,
  output logic                   s_tready_o,
  input  wire phist_status_t     status_i,
  output phist_cmd_t             cmd_o
);

  typedef enum logic [3:0] {
    ST_INIT   = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_CLEAR  = 4'b0100,
    ST_LOOKUP = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  phist_mode_e mode;

  assign mode = phist_mode_e'(mode_i);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load_item = 1'b1;
          if (mode == MODE_CLEAR) begin
            state_d = ST_CLEAR;
          end else if (mode inside {MODE_COUNT, MODE_READ}) begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (status_i.item_read) begin
          // hold until the result register drains
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_lookup_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |->
      ($past(state_q) == ST_IDLE || $past(state_q) == ST_LOOKUP))
    else $error("lookup entered without an accepted request");

endmodule
`default_nettype wire

// ===== src/phist_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phist_dp: datapath of the pixel histogram unit
// Bin memory, sweep pointer, saturating increment and result register.
// ----------------------------------------------------------------------------
module phist_dp
  import phist_pkg::*;
#(
  parameter int unsigned BINS        = BINS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [PIXEL_W-1:0]     pixel_i,
  input  wire logic [MODE_W-1:0]      mode_i,
  input  wire phist_cmd_t             cmd_i,
  output phist_status_t               status_o,
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i,
  output logic      [OUT_TDATA_W-1:0] m_tdata_o
);

  localparam int unsigned AW = $clog2(BINS);

  logic [PIXEL_W-1:0]     item_pixel_q;
  logic                   item_read_q;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic                   sweep_last;
  logic [AW-1:0]          raddr, waddr, item_addr;
  logic                   we;
  logic [COUNT_WIDTH-1:0] rdata, wdata, inc;
  logic                   full, in_range;
  logic [OUT_COUNT_W-1:0] rd_count, res_count;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_pixel_q <= pixel_i;
      item_read_q  <= (phist_mode_e'(mode_i) == MODE_READ);
    end
  end

  assign item_addr = AW'(item_pixel_q);
  assign in_range  = 32'(item_pixel_q) < 32'(BINS);

  // Read the incoming pixel's bin in the accept cycle, then hold it
  assign raddr = cmd_i.load_item ? AW'(pixel_i) : item_addr;

  // Sweep pointer
  assign sweep_last = (ptr_q == AW'(BINS - 1));
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.sweep) begin
      ptr_d = sweep_last ? '0 : ptr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // Saturating increment
  assign full  = &rdata;
  assign inc   = rdata + COUNT_WIDTH'(1);
  assign waddr = cmd_i.sweep ? ptr_q : item_addr;
  assign wdata = cmd_i.sweep ? '0 : inc;
  assign we    = cmd_i.sweep || (cmd_i.update && in_range && !full);

  phist_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  generate
    if (COUNT_WIDTH > OUT_COUNT_W) begin : g_sat
      assign rd_count = (|rdata[COUNT_WIDTH-1:OUT_COUNT_W]) ? '1
                                                            : rdata[OUT_COUNT_W-1:0];
    end else begin : g_ext
      assign rd_count = OUT_COUNT_W'(rdata);
    end
  endgenerate

  assign res_count = in_range ? rd_count : '0;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {res_count, item_pixel_q};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  assign status_o.sweep_last = sweep_last;
  assign status_o.out_free   = !out_valid_q || m_tready_i;
  assign status_o.item_read  = item_read_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || m_tready_i))
    else $error("result register overwritten");

  a_sweep_xor_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.sweep && (cmd_i.update || cmd_i.load_item)))
    else $error("bin write during clearing sweep");

  a_sweep_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sweep && sweep_last) |=> (ptr_q == '0))
    else $error("sweep pointer not back at zero");

endmodule
`default_nettype wire

// ===== src/pixel_histogram_256_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_histogram_256_unit: histogram of 8-bit pixel values
// Clears, counts into and reads back BINS saturating bin counters.
// ----------------------------------------------------------------------------
//  channel | dir | tuser       | tdata (lowest bit up)
//  --------+-----+-------------+--------------------------------------------
//  s_*     | in  | mode [1:0]  | pixel_value [7:0]
//  m_*     | out | -           | bin_index [7:0], bin_count [39:8]
//
// A count request runs the bin memory's registered read, then the saturating
// write back. A read request runs the same read, then loads the result
// register, waiting while that register is still held by a stalled m_tready_i.
// A clear request zeroes every bin, one bin per cycle through the write port.
// Reset runs the same clearing sweep; s_tready_o stays low during it. One
// request is in work at a time; unused mode codes are taken and dropped.
// ----------------------------------------------------------------------------
module pixel_histogram_256_unit
  import phist_pkg::*;
#(
  parameter int unsigned BINS        = BINS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  output logic                        s_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata_i,   // pixel_value
  input  wire logic [MODE_W-1:0]      s_tuser_i,   // mode
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i,
  output logic      [OUT_TDATA_W-1:0] m_tdata_o    // bin_index, bin_count
);

  phist_cmd_t    cmd;
  phist_status_t status;

  // Sequence sweeps and bin updates
  phist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .mode_i     (s_tuser_i),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the bins and the pending result
  phist_dp #(
    .BINS        (BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pixel_i    (s_tdata_i[PIXEL_W-1:0]),
    .mode_i     (s_tuser_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

endmodule
`default_nettype wire
